// File: rtl/wsp_pkg.sv
// Shared types and constants for the world-to-screen projection pipeline.
package wsp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int LANE_W          = 32;
    localparam int CFG_DATA_W      = 2 * LANE_W;
    localparam int CFG_IDX_W       = 3;
    localparam int DIM_W           = 14;
    localparam int ROWS            = 3;
    localparam int ROW_X           = 0;
    localparam int ROW_Y           = 1;
    localparam int ROW_W           = 2;

    localparam logic [DIM_W-1:0] SCREEN_W_RESET = DIM_W'(1920);
    localparam logic [DIM_W-1:0] SCREEN_H_RESET = DIM_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_XY = 3'd0,
        REG_ROW0_ZW = 3'd1,
        REG_ROW1_XY = 3'd2,
        REG_ROW1_ZW = 3'd3,
        REG_ROW3_XY = 3'd4,
        REG_ROW3_ZW = 3'd5,
        REG_SCREEN_W = 3'd6,
        REG_SCREEN_H = 3'd7
    } cfg_reg_idx_t;

    typedef struct packed {
        logic vis;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } wsp_flags_t;

    function automatic int sum_width(input int cw, input int fb);
        return cw + LANE_W - fb + 2;
    endfunction

endpackage

// File: rtl/wsp_ifs.sv
// Stream and configuration interfaces of the projection block.
interface wsp_point_if import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface wsp_pixel_if import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          visible;
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface wsp_cfg_if import wsp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/world_to_screen_projection.sv
// Projects world points to screen coordinates through a fixed-point view-projection pipeline.
// One point enters per clock unless the pipeline is held. Each point passes through two stages
// of products and row sums, one stage for the visibility test, COORD_WIDTH + 2 divider
// stages that each settle one quotient bit, and three stages of scaling and saturation
// ending in the output register. The whole pipeline holds when the result is not taken.
// Configuration writes are accepted in any cycle and must only be issued while no point is
// in flight.
module world_to_screen_projection import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wsp_point_if.sink  points,
    wsp_pixel_if.source pixels,
    wsp_cfg_if.sink    cfg
);

    localparam int SUM_W = sum_width(COORD_WIDTH, FRAC_BITS);

    logic [ROWS-1:0][CFG_DATA_W-1:0] row_xy_reg, row_zw_reg;
    logic [DIM_W-1:0]                screen_w_reg, screen_h_reg;

    logic                    en;
    logic                    dot_valid, div_valid, out_valid;
    logic signed [SUM_W-1:0] sums [ROWS];
    wsp_flags_t              div_flags;
    logic [COORD_WIDTH+1:0]  quot_x, quot_y;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_xy_reg   <= '0;
            row_zw_reg   <= '0;
            screen_w_reg <= SCREEN_W_RESET;
            screen_h_reg <= SCREEN_H_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_idx_t'(cfg.index))
                REG_ROW0_XY:  row_xy_reg[ROW_X] <= cfg.data;
                REG_ROW0_ZW:  row_zw_reg[ROW_X] <= cfg.data;
                REG_ROW1_XY:  row_xy_reg[ROW_Y] <= cfg.data;
                REG_ROW1_ZW:  row_zw_reg[ROW_Y] <= cfg.data;
                REG_ROW3_XY:  row_xy_reg[ROW_W] <= cfg.data;
                REG_ROW3_ZW:  row_zw_reg[ROW_W] <= cfg.data;
                REG_SCREEN_W: screen_w_reg <= cfg.data[DIM_W-1:0];
                REG_SCREEN_H: screen_h_reg <= cfg.data[DIM_W-1:0];
            endcase
        end
    end

    assign en           = !out_valid || pixels.ready;
    assign points.ready = en;

    wsp_dot #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (points.valid),
        .pt_x      (points.point_x),
        .pt_y      (points.point_y),
        .pt_z      (points.point_z),
        .row_xy    (row_xy_reg),
        .row_zw    (row_zw_reg),
        .out_valid (dot_valid),
        .sums      (sums)
    );

    wsp_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .nx        (sums[ROW_X]),
        .ny        (sums[ROW_Y]),
        .w         (sums[ROW_W]),
        .out_valid (div_valid),
        .flags     (div_flags),
        .quot_x    (quot_x),
        .quot_y    (quot_y)
    );

    wsp_scale #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .flags     (div_flags),
        .quot_x    (quot_x),
        .quot_y    (quot_y),
        .screen_w  (screen_w_reg),
        .screen_h  (screen_h_reg),
        .out_valid (out_valid),
        .visible   (pixels.visible),
        .screen_x  (pixels.screen_x),
        .screen_y  (pixels.screen_y)
    );

    assign pixels.valid = out_valid;

endmodule

// File: rtl/wsp_dot.sv
// Two-stage dot products of the point with matrix rows 0, 1 and 3.
module wsp_dot import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  logic signed [COORD_WIDTH-1:0]                pt_x,
    input  logic signed [COORD_WIDTH-1:0]                pt_y,
    input  logic signed [COORD_WIDTH-1:0]                pt_z,
    input  logic [ROWS-1:0][CFG_DATA_W-1:0]              row_xy,
    input  logic [ROWS-1:0][CFG_DATA_W-1:0]              row_zw,
    output logic                                         out_valid,
    output logic signed [sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sums [ROWS]
);

    localparam int PROD_W = LANE_W + COORD_WIDTH;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = sum_width(COORD_WIDTH, FRAC_BITS);

    logic [1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    assign out_valid = v_reg[1];

    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        logic signed [LANE_W-1:0] cx, cy, cz, ct;
        logic signed [PROD_W-1:0] px_next, py_next, pz_next;
        logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
        logic signed [LANE_W-1:0] ct_reg;
        logic signed [TERM_W-1:0] tx, ty, tz;
        logic signed [SUM_W-1:0]  sum_next, sum_reg;

        assign cx = row_xy[r][LANE_W-1:0];
        assign cy = row_xy[r][CFG_DATA_W-1:LANE_W];
        assign cz = row_zw[r][LANE_W-1:0];
        assign ct = row_zw[r][CFG_DATA_W-1:LANE_W];

        assign px_next = PROD_W'(cx) * PROD_W'(pt_x);
        assign py_next = PROD_W'(cy) * PROD_W'(pt_y);
        assign pz_next = PROD_W'(cz) * PROD_W'(pt_z);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                px_reg <= px_next;
                py_reg <= py_next;
                pz_reg <= pz_next;
                ct_reg <= ct;
            end
        end

        // floor to the fraction grid before summing
        assign tx = TERM_W'(px_reg >>> FRAC_BITS);
        assign ty = TERM_W'(py_reg >>> FRAC_BITS);
        assign tz = TERM_W'(pz_reg >>> FRAC_BITS);
        assign sum_next = SUM_W'(tx) + SUM_W'(ty) + SUM_W'(tz) + SUM_W'(ct_reg);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg <= sum_next;
            end
        end

        assign sums[r] = sum_reg;
    end

endmodule

// File: rtl/wsp_div.sv
// Visibility test and pipelined restoring divider, one quotient bit per stage.
module wsp_div import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  logic                                                in_valid,
    input  logic signed [sum_width(COORD_WIDTH, FRAC_BITS)-1:0] nx,
    input  logic signed [sum_width(COORD_WIDTH, FRAC_BITS)-1:0] ny,
    input  logic signed [sum_width(COORD_WIDTH, FRAC_BITS)-1:0] w,
    output logic                                                out_valid,
    output wsp_flags_t                                          flags,
    output logic [COORD_WIDTH+1:0]                              quot_x,
    output logic [COORD_WIDTH+1:0]                              quot_y
);

    localparam int SUM_W = sum_width(COORD_WIDTH, FRAC_BITS);
    localparam int QB    = COORD_WIDTH + 2;
    localparam int DIV_W = SUM_W + QB;
    localparam int W_MIN = ((1 << FRAC_BITS) + 500) / 1000;

    logic [SUM_W-1:0] mag_x, mag_y, den;
    logic [DIV_W-1:0] dvd_x, dvd_y, dlim;
    wsp_flags_t       flags_next;

    logic             v_reg     [QB+1];
    wsp_flags_t       flags_reg [QB+1];
    logic [SUM_W-1:0] den_reg   [QB+1];
    logic [DIV_W-1:0] rem_x_reg [QB+1];
    logic [DIV_W-1:0] rem_y_reg [QB+1];
    logic [QB-1:0]    q_x_reg   [QB+1];
    logic [QB-1:0]    q_y_reg   [QB+1];

    always_comb
    begin
        mag_x = nx[SUM_W-1] ? SUM_W'(-nx) : SUM_W'(nx);
        mag_y = ny[SUM_W-1] ? SUM_W'(-ny) : SUM_W'(ny);
        den   = w;
        dvd_x = DIV_W'(mag_x) << FRAC_BITS;
        dvd_y = DIV_W'(mag_y) << FRAC_BITS;
        dlim  = DIV_W'(den) << QB;
        flags_next.vis   = (w >= $signed(SUM_W'(W_MIN)));
        flags_next.neg_x = nx[SUM_W-1];
        flags_next.neg_y = ny[SUM_W-1];
        flags_next.ovf_x = (dvd_x >= dlim);
        flags_next.ovf_y = (dvd_y >= dlim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg[0] <= flags_next;
            den_reg[0]   <= den;
            rem_x_reg[0] <= dvd_x;
            rem_y_reg[0] <= dvd_y;
            q_x_reg[0]   <= '0;
            q_y_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [DIV_W-1:0] sh;
        logic             gx, gy;

        assign sh = DIV_W'(den_reg[k]) << (QB - 1 - k);
        assign gx = (rem_x_reg[k] >= sh);
        assign gy = (rem_y_reg[k] >= sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flags_reg[k+1] <= flags_reg[k];
                den_reg[k+1]   <= den_reg[k];
                rem_x_reg[k+1] <= gx ? rem_x_reg[k] - sh : rem_x_reg[k];
                rem_y_reg[k+1] <= gy ? rem_y_reg[k] - sh : rem_y_reg[k];
                q_x_reg[k+1]   <= {q_x_reg[k][QB-2:0], gx};
                q_y_reg[k+1]   <= {q_y_reg[k][QB-2:0], gy};
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign flags     = flags_reg[QB];
    assign quot_x    = q_x_reg[QB];
    assign quot_y    = q_y_reg[QB];

`ifndef NO_ASSERTIONS
    a_rem_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QB] && flags_reg[QB].vis && !flags_reg[QB].ovf_x
        |-> rem_x_reg[QB] < DIV_W'(den_reg[QB]))
        else $error("x remainder not below divisor");
    a_rem_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QB] && flags_reg[QB].vis && !flags_reg[QB].ovf_y
        |-> rem_y_reg[QB] < DIV_W'(den_reg[QB]))
        else $error("y remainder not below divisor");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg[QB]) && $stable(q_x_reg[QB]) && $stable(q_y_reg[QB]))
        else $error("divider advanced while stalled");
`endif

endmodule

// File: rtl/wsp_scale.sv
// Ratio capping, viewport scaling, halving and saturation; holds the output register.
module wsp_scale import wsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  wsp_flags_t                    flags,
    input  logic [COORD_WIDTH+1:0]        quot_x,
    input  logic [COORD_WIDTH+1:0]        quot_y,
    input  logic [DIM_W-1:0]              screen_w,
    input  logic [DIM_W-1:0]              screen_h,
    output logic                          out_valid,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] screen_x,
    output logic signed [COORD_WIDTH-1:0] screen_y
);

    localparam int QB    = COORD_WIDTH + 2;
    localparam int T_W   = QB + 2;
    localparam int MUL_W = T_W + DIM_W + 1;

    localparam logic [QB-1:0]           CAP    = QB'(1) << (COORD_WIDTH + 1);
    localparam logic signed [T_W-1:0]   ONE    = T_W'(1) << FRAC_BITS;
    localparam logic signed [MUL_W-1:0] SAT_HI = (MUL_W'(1) << (COORD_WIDTH - 1)) - MUL_W'(1);
    localparam logic signed [MUL_W-1:0] SAT_LO = -(MUL_W'(1) << (COORD_WIDTH - 1));

    logic [QB-1:0]           cap_x, cap_y;
    logic signed [QB:0]      r_x, r_y;
    logic signed [T_W-1:0]   t_x_next, t_y_next, t_x_reg, t_y_reg;
    logic signed [MUL_W-1:0] m_x_reg, m_y_reg, h_x, h_y;
    logic [2:0]              v_reg;
    logic                    vis1_reg, vis2_reg;
    logic                    vis_reg;
    logic signed [COORD_WIDTH-1:0] sx_next, sy_next, sx_reg, sy_reg;

    always_comb
    begin
        cap_x    = (flags.ovf_x || quot_x > CAP) ? CAP : quot_x;
        cap_y    = (flags.ovf_y || quot_y > CAP) ? CAP : quot_y;
        r_x      = flags.neg_x ? -(QB+1)'(cap_x) : (QB+1)'(cap_x);
        r_y      = flags.neg_y ? -(QB+1)'(cap_y) : (QB+1)'(cap_y);
        t_x_next = ONE + T_W'(r_x);
        t_y_next = ONE - T_W'(r_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_x_reg  <= t_x_next;
            t_y_reg  <= t_y_next;
            vis1_reg <= flags.vis;
            m_x_reg  <= MUL_W'(t_x_reg) * $signed(MUL_W'(screen_w));
            m_y_reg  <= MUL_W'(t_y_reg) * $signed(MUL_W'(screen_h));
            vis2_reg <= vis1_reg;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            vis_reg  <= vis2_reg;
        end
    end

    always_comb
    begin
        h_x = m_x_reg >>> 1;
        h_y = m_y_reg >>> 1;
        priority if (!vis2_reg)
            sx_next = '0;
        else if (h_x > SAT_HI)
            sx_next = COORD_WIDTH'(SAT_HI);
        else if (h_x < SAT_LO)
            sx_next = COORD_WIDTH'(SAT_LO);
        else
            sx_next = COORD_WIDTH'(h_x);
        priority if (!vis2_reg)
            sy_next = '0;
        else if (h_y > SAT_HI)
            sy_next = COORD_WIDTH'(SAT_HI);
        else if (h_y < SAT_LO)
            sy_next = COORD_WIDTH'(SAT_LO);
        else
            sy_next = COORD_WIDTH'(h_y);
    end

    assign out_valid = v_reg[2];
    assign visible   = vis_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;

endmodule
